// File: src/rbc_pkg.sv
// ----------------------------------------------------------------------------
// Package for the two-class recursive Bayes classifier.
// Shared sizes, codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Table depths and number format.
  localparam int SPEED_BINS     = 512;
  localparam int VARIATION_BINS = 256;
  localparam int PROB_FRAC_BITS = 16;
  localparam int PROB_W         = 17;
  localparam int SPD_AW         = $clog2(SPEED_BINS);
  localparam int VAR_AW         = $clog2(VARIATION_BINS);
  localparam int LIK_W          = 16;
  localparam int JOINT_W        = 2 * LIK_W;

  localparam logic [PROB_W-1:0] PROB_ONE    = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [PROB_W-1:0] PROB_HALF   = PROB_ONE >> 1;
  localparam logic [PROB_W-1:0] PRIOR_RESET = PROB_HALF;

  // Posterior datapath widths.
  localparam int NUM_W         = PROB_W + JOINT_W;
  localparam int EV_LIMIT_BITS = 40;
  localparam int SHIFT_MAX     = NUM_W - EV_LIMIT_BITS;
  localparam int SH_W          = $clog2(SHIFT_MAX + 1);
  localparam int DVD_W         = EV_LIMIT_BITS + PROB_FRAC_BITS + 1;
  localparam int QUO_W         = PROB_W;
  localparam int DIV_CNT_W     = $clog2(QUO_W);

  // Command queue depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Opcodes of the request channel.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // Table selects.
  localparam logic [1:0] SEL_BIRD_SPEED  = 2'd0;
  localparam logic [1:0] SEL_PLANE_SPEED = 2'd1;
  localparam logic [1:0] SEL_BIRD_VAR    = 2'd2;
  localparam logic [1:0] SEL_PLANE_VAR   = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_OBSERVE,
    CMD_START
  } cmd_e;

  // Classified command as it travels through the queue.
  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  table_select;
    logic [8:0]  table_index;
    logic [15:0] table_value;
    logic        speed_ok;
    logic [8:0]  speed_bin;
    logic        var_ok;
    logic [7:0]  variation_bin;
  } cmd_t;

endpackage

// File: src/rbc_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces of the classifier.
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  table_select;
  logic [8:0]  table_index;
  logic [15:0] table_value;
  logic        speed_valid;
  logic [8:0]  speed_bin;
  logic        variation_valid;
  logic [7:0]  variation_bin;

  modport source (output valid, opcode, table_select, table_index, table_value,
                  speed_valid, speed_bin, variation_valid, variation_bin,
                  input ready);
  modport sink (input valid, opcode, table_select, table_index, table_value,
                speed_valid, speed_bin, variation_valid, variation_bin,
                output ready);
endinterface

interface rbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [16:0] plane_prob;
  logic [16:0] bird_prob;
  logic        is_bird;
  logic        used_fallback;
  logic        zero_evidence;

  modport source (output valid, plane_prob, bird_prob, is_bird,
                  used_fallback, zero_evidence, input ready);
  modport sink (input valid, plane_prob, bird_prob, is_bird,
                used_fallback, zero_evidence, output ready);
endinterface

interface rbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: src/rbc_front.sv
// ----------------------------------------------------------------------------
// Classifier front end.
// Accepts requests, decodes the opcode and range checks the bins.
// ----------------------------------------------------------------------------
module rbc_front
  import rbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rbc_req_if.sink    req_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o,
  input  logic       push_ready_i
);

  logic hold_valid_q;
  cmd_t cmd_q;
  cmd_t cmd_d;
  logic known_op;

  // The holding register frees up when the queue takes its command.
  assign req_i.ready = !hold_valid_q || push_ready_i;

  // Decode the opcode; the unused code is accepted and dropped.
  always_comb begin
    cmd_d               = '0;
    known_op            = 1'b1;
    cmd_d.table_select  = req_i.table_select;
    cmd_d.table_index   = req_i.table_index;
    cmd_d.table_value   = req_i.table_value;
    cmd_d.speed_bin     = req_i.speed_bin;
    cmd_d.variation_bin = req_i.variation_bin;
    cmd_d.speed_ok      = req_i.speed_valid && (32'(req_i.speed_bin) < SPEED_BINS);
    cmd_d.var_ok        = req_i.variation_valid &&
                          (32'(req_i.variation_bin) < VARIATION_BINS);
    unique case (req_i.opcode)
      OP_LOAD:    cmd_d.cmd = CMD_LOAD;
      OP_OBSERVE: cmd_d.cmd = CMD_OBSERVE;
      OP_START:   cmd_d.cmd = CMD_START;
      default: begin
        cmd_d.cmd = CMD_LOAD;
        known_op  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      hold_valid_q <= req_i.valid && known_op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_valid_o = hold_valid_q;
  assign push_cmd_o   = cmd_q;

endmodule

// File: src/rbc_queue.sv
// ----------------------------------------------------------------------------
// Command queue.
// Short register queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module rbc_queue
  import rbc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  cmd_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: src/rbc_back.sv
// ----------------------------------------------------------------------------
// Classifier back end.
// Holds the likelihood tables and beliefs and runs the Bayes updates with
// multiply states shared by both updates and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module rbc_back
  import rbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PROB_W-1:0] prior_i,
  input  logic              pop_valid_i,
  input  cmd_t              pop_cmd_i,
  output logic              pop_ready_o,
  rbc_rsp_if.source         rsp_o
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_READ    = 10'b0000000010,
    ST_JOINT   = 10'b0000000100,
    ST_MUL_OWN = 10'b0000001000,
    ST_MUL_OTH = 10'b0000010000,
    ST_SUM     = 10'b0000100000,
    ST_NORM    = 10'b0001000000,
    ST_DIV     = 10'b0010000000,
    ST_STORE   = 10'b0100000000,
    ST_REPORT  = 10'b1000000000
  } state_e;

  state_e state_q;

  // Likelihood tables.
  logic [LIK_W-1:0] bird_spd_mem  [SPEED_BINS];
  logic [LIK_W-1:0] plane_spd_mem [SPEED_BINS];
  logic [LIK_W-1:0] bird_var_mem  [VARIATION_BINS];
  logic [LIK_W-1:0] plane_var_mem [VARIATION_BINS];
  logic [LIK_W-1:0] lbs_q, lps_q, lbv_q, lpv_q;

  // Beliefs and report state.
  logic [PROB_W-1:0] bird_q, plane_q, rep_q, prior_clamp;
  logic              rep_valid_q, zero_q, joint_q, phase_plane_q;

  // Datapath registers.
  logic [PROB_W-1:0]        op_p_q;
  logic [JOINT_W-1:0]       op_own_q, op_oth_q;
  logic [NUM_W-1:0]         num_q, oth_q, ev_q;
  logic [EV_LIMIT_BITS-1:0] rem_q, dvs_q;
  logic [QUO_W-1:0]         low_q, quo_q;
  logic [DIV_CNT_W-1:0]     cnt_q;

  logic                     take, is_load, is_start, is_obs, out_free;
  logic [SH_W-1:0]          shift_amt;
  logic [NUM_W-1:0]         ev_sh, num_sh;
  logic [DVD_W-1:0]         dvd;
  logic [EV_LIMIT_BITS:0]   trial;
  logic                     trial_ge;
  logic [PROB_W-1:0]        res_clamp;
  logic [PROB_W-1:0]        out_plane, out_bird;
  logic                     out_is_bird, out_fallback;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign take        = pop_valid_i && pop_ready_o;
  assign is_load     = take && (pop_cmd_i.cmd == CMD_LOAD);
  assign is_start    = take && (pop_cmd_i.cmd == CMD_START);
  assign is_obs      = take && (pop_cmd_i.cmd == CMD_OBSERVE);
  assign prior_clamp = (prior_i > PROB_ONE) ? PROB_ONE : prior_i;
  assign out_free    = !rsp_o.valid || rsp_o.ready;

  // Table writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (is_load && (32'(pop_cmd_i.table_index) < SPEED_BINS)) begin
      if (pop_cmd_i.table_select == SEL_BIRD_SPEED) begin
        bird_spd_mem[SPD_AW'(pop_cmd_i.table_index)] <= pop_cmd_i.table_value;
      end
      if (pop_cmd_i.table_select == SEL_PLANE_SPEED) begin
        plane_spd_mem[SPD_AW'(pop_cmd_i.table_index)] <= pop_cmd_i.table_value;
      end
    end
    if (is_load && (32'(pop_cmd_i.table_index) < VARIATION_BINS)) begin
      if (pop_cmd_i.table_select == SEL_BIRD_VAR) begin
        bird_var_mem[VAR_AW'(pop_cmd_i.table_index)] <= pop_cmd_i.table_value;
      end
      if (pop_cmd_i.table_select == SEL_PLANE_VAR) begin
        plane_var_mem[VAR_AW'(pop_cmd_i.table_index)] <= pop_cmd_i.table_value;
      end
    end
    if (is_obs) begin
      lbs_q <= bird_spd_mem[SPD_AW'(pop_cmd_i.speed_bin)];
      lps_q <= plane_spd_mem[SPD_AW'(pop_cmd_i.speed_bin)];
      lbv_q <= bird_var_mem[VAR_AW'(pop_cmd_i.variation_bin)];
      lpv_q <= plane_var_mem[VAR_AW'(pop_cmd_i.variation_bin)];
    end
  end

  // Normalization shift so that the evidence fits the divider.
  always_comb begin
    shift_amt = '0;
    for (int i = 0; i < SHIFT_MAX; i++) begin
      if (ev_q[EV_LIMIT_BITS + i]) begin
        shift_amt = SH_W'(i + 1);
      end
    end
    ev_sh  = ev_q >> shift_amt;
    num_sh = num_q >> shift_amt;
    dvd    = DVD_W'({num_sh[EV_LIMIT_BITS-1:0], PROB_FRAC_BITS'(0)}) +
             DVD_W'(ev_sh[EV_LIMIT_BITS-1:1]);
  end

  // One quotient bit per cycle.
  assign trial     = {rem_q, low_q[QUO_W-1]};
  assign trial_ge  = (trial >= {1'b0, dvs_q});
  assign res_clamp = (quo_q > PROB_ONE) ? PROB_ONE : quo_q;

  // Result fields from the report state.
  always_comb begin
    if (rep_valid_q) begin
      out_plane    = rep_q;
      out_bird     = PROB_ONE - rep_q;
      out_is_bird  = (rep_q <= PROB_HALF);
      out_fallback = 1'b0;
    end else begin
      out_bird     = bird_q;
      out_plane    = PROB_ONE - bird_q;
      out_is_bird  = (bird_q >= PROB_HALF);
      out_fallback = 1'b1;
    end
  end

  // Sequencer and belief state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      bird_q        <= PRIOR_RESET;
      plane_q       <= PRIOR_RESET;
      rep_q         <= '0;
      rep_valid_q   <= 1'b0;
      zero_q        <= 1'b0;
      joint_q       <= 1'b0;
      phase_plane_q <= 1'b0;
      rsp_o.valid   <= 1'b0;
    end else begin
      // The result register fills in the report state and empties on a handshake.
      if (state_q == ST_REPORT && out_free) begin
        rsp_o.valid <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        rsp_o.valid <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (is_start) begin
            bird_q      <= prior_clamp;
            plane_q     <= prior_clamp;
            rep_q       <= '0;
            rep_valid_q <= 1'b0;
          end
          if (is_obs) begin
            zero_q  <= 1'b0;
            joint_q <= pop_cmd_i.var_ok;
            state_q <= pop_cmd_i.speed_ok ? ST_READ : ST_REPORT;
          end
        end
        ST_READ: begin
          phase_plane_q <= 1'b0;
          op_p_q        <= bird_q;
          op_own_q      <= JOINT_W'(lbs_q);
          op_oth_q      <= JOINT_W'(lps_q);
          state_q       <= ST_MUL_OWN;
        end
        ST_JOINT: begin
          phase_plane_q <= 1'b1;
          op_p_q        <= plane_q;
          if (joint_q) begin
            op_own_q <= JOINT_W'(lps_q) * JOINT_W'(lpv_q);
            op_oth_q <= JOINT_W'(lbs_q) * JOINT_W'(lbv_q);
          end else begin
            op_own_q <= JOINT_W'(lps_q);
            op_oth_q <= JOINT_W'(lbs_q);
          end
          state_q <= ST_MUL_OWN;
        end
        ST_MUL_OWN: begin
          num_q   <= NUM_W'(op_p_q) * NUM_W'(op_own_q);
          state_q <= ST_MUL_OTH;
        end
        ST_MUL_OTH: begin
          oth_q   <= NUM_W'(PROB_ONE - op_p_q) * NUM_W'(op_oth_q);
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          ev_q    <= num_q + oth_q;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (ev_q == '0) begin
            // Zero evidence: hold the belief and flag the sample.
            zero_q <= 1'b1;
            if (phase_plane_q) begin
              rep_valid_q <= 1'b0;
              state_q     <= ST_REPORT;
            end else begin
              state_q <= ST_JOINT;
            end
          end else begin
            dvs_q   <= ev_sh[EV_LIMIT_BITS-1:0];
            rem_q   <= dvd[DVD_W-1:QUO_W];
            low_q   <= dvd[QUO_W-1:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= trial_ge ? EV_LIMIT_BITS'(trial - {1'b0, dvs_q})
                            : trial[EV_LIMIT_BITS-1:0];
          low_q <= {low_q[QUO_W-2:0], 1'b0};
          quo_q <= {quo_q[QUO_W-2:0], trial_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (phase_plane_q) begin
            if (joint_q) begin
              plane_q <= res_clamp;
            end
            rep_q       <= res_clamp;
            rep_valid_q <= 1'b1;
            state_q     <= ST_REPORT;
          end else begin
            bird_q  <= res_clamp;
            state_q <= ST_JOINT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_REPORT && out_free) begin
      rsp_o.plane_prob    <= out_plane;
      rsp_o.bird_prob     <= out_bird;
      rsp_o.is_bird       <= out_is_bird;
      rsp_o.used_fallback <= out_fallback;
      rsp_o.zero_evidence <= zero_q;
    end
  end

endmodule

// File: src/recursive_bayes_two_class_core.sv
// ----------------------------------------------------------------------------
// Two-class recursive Bayes classifier, top level.
// Bird versus plane beliefs updated from radar speed and variation samples.
//
// Channels: req_i carries load, observe and start requests; rsp_o returns
// one result per observe request; cfg_i writes the initial prior, which is
// always ready and should only be written while the block is idle.
// Load and start requests give no result and retire as soon as the back end
// takes them; unknown codes are dropped by the front end. An accepted request
// passes the front holding register and the queue before it reaches the back
// end. An observe request with a speed sample runs two Bayes updates, each
// one multiply pair plus a restoring division, between the queue and the
// result register; without a speed sample it goes straight to the report
// state. The divider sets the throughput; the back end takes the next request only once it is idle again.
// A front register and a two-entry queue keep accepting requests while the
// back end works. When the receiver stalls, the result stays in its output
// register and the back end waits before writing the next one.
// Reset sets both beliefs and the prior to one half and clears the report;
// the likelihood tables hold no defined value until loaded.
// ----------------------------------------------------------------------------
module recursive_bayes_two_class_core
  import rbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rbc_req_if.sink    req_i,
  rbc_rsp_if.source  rsp_o,
  rbc_cfg_if.sink    cfg_i
);

  logic [PROB_W-1:0] prior_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  cmd_t              push_cmd, pop_cmd;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= PRIOR_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      prior_q <= cfg_i.data;
    end
  end

  rbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  rbc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  rbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prior_i     (prior_q),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

endmodule

// File: src/rbc_checker.sv
// ----------------------------------------------------------------------------
// Classifier port checker.
// Checks result consistency and output behavior seen at the top level.
// ----------------------------------------------------------------------------
module rbc_checker
  import rbc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [PROB_W-1:0] plane_i,
  input logic [PROB_W-1:0] bird_i,
  input logic              is_bird_i,
  input logic              fallback_i
);

  // No result is offered while in reset.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("result valid during reset");

  // The two probabilities always add up to one.
  a_sum_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ({1'b0, plane_i} + {1'b0, bird_i}) == {1'b0, PROB_ONE})
    else $error("probabilities do not sum to one");

  // The conclusion follows the reported probability.
  a_conclusion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (fallback_i ? (is_bird_i == (bird_i >= PROB_HALF))
                                : (is_bird_i == (plane_i <= PROB_HALF))))
    else $error("conclusion does not match probabilities");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(plane_i) &&
                                    $stable(bird_i))
    else $error("stalled result changed");

endmodule

bind recursive_bayes_two_class_core rbc_checker u_rbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .plane_i     (rsp_o.plane_prob),
  .bird_i      (rsp_o.bird_prob),
  .is_bird_i   (rsp_o.is_bird),
  .fallback_i  (rsp_o.used_fallback)
);
